[rtl/gss_pkg.sv]
// Package for the generational sparse set: sizes, request and status codes,
// and the command struct from the controller to the datapath. No dependencies.
`default_nettype none

package gss_pkg;

    localparam int SLOT_COUNT = 1024;
    localparam int IDX_W      = $clog2(SLOT_COUNT);
    localparam int CNT_W      = IDX_W + 1;
    localparam int GEN_WIDTH  = 16;
    localparam int DATA_W     = 32;
    localparam int REQ_W      = 3;
    localparam int STAT_W     = 2;

    localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(SLOT_COUNT);
    localparam logic [CNT_W-1:0] SLOT_TOTAL  = CNT_W'(SLOT_COUNT);

    localparam logic [REQ_W-1:0] REQ_CREATE = 3'd0;
    localparam logic [REQ_W-1:0] REQ_ADD    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd2;
    localparam logic [REQ_W-1:0] REQ_LOOKUP = 3'd3;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_STALE   = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STAT_W-1:0] ST_ABSENT  = 2'd3;

    typedef struct packed {
        logic accept;
        logic link;
        logic exec;
    } t_cmd;

endpackage

`default_nettype wire

[rtl/gss_ctrl.sv]
// Request sequencer for the generational sparse set: accept, link read, execute.
// Depends on gss_pkg for the command struct.
`default_nettype none

module gss_ctrl
    import gss_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    output logic      o_busy,
    output t_cmd      o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_LINK = 3'b010,
        S_EXEC = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_LINK;
                end
            end
            S_LINK: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy       = (r_state != S_IDLE);
    assign o_cmd.accept = (r_state == S_IDLE) && i_start;
    assign o_cmd.link   = (r_state == S_LINK);
    assign o_cmd.exec   = (r_state == S_EXEC);

endmodule

`default_nettype wire

[rtl/gss_dp.sv]
// Datapath of the generational sparse set: counters, link and payload memories,
// request execution and the result register. Depends on gss_pkg.
`default_nettype none

module gss_dp
    import gss_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cmd               i_cmd,
    input  wire logic               i_cfg_wr_en,
    input  wire logic [CNT_W-1:0]   i_cfg_wr_data,
    input  wire logic [REQ_W-1:0]   i_req_type,
    input  wire logic [IDX_W-1:0]   i_entity_index,
    input  wire logic [GEN_WIDTH-1:0] i_generation,
    input  wire logic [DATA_W-1:0]  i_payload_x,
    input  wire logic [DATA_W-1:0]  i_payload_y,
    input  wire logic [DATA_W-1:0]  i_payload_size,
    output logic                    o_result_valid,
    output logic [STAT_W-1:0]       o_out_status,
    output logic [IDX_W-1:0]        o_new_index,
    output logic [GEN_WIDTH-1:0]    o_new_generation,
    output logic [IDX_W-1:0]        o_slot_index,
    output logic [DATA_W-1:0]       o_read_x,
    output logic [DATA_W-1:0]       o_read_y,
    output logic [DATA_W-1:0]       o_read_size,
    output logic [CNT_W-1:0]        o_live_count
);

    logic [GEN_WIDTH-1:0] mem_gen [SLOT_COUNT];
    logic [IDX_W-1:0]     mem_fs  [SLOT_COUNT];
    logic [IDX_W-1:0]     mem_s2e [SLOT_COUNT];
    logic [IDX_W-1:0]     mem_e2s [SLOT_COUNT];
    logic [DATA_W-1:0]    mem_x   [SLOT_COUNT];
    logic [DATA_W-1:0]    mem_y   [SLOT_COUNT];
    logic [DATA_W-1:0]    mem_sz  [SLOT_COUNT];

    logic [CNT_W-1:0] r_slot_limit;
    logic [CNT_W-1:0] r_free_depth, n_free_depth;
    logic [CNT_W-1:0] r_fresh_next, n_fresh_next;
    logic [CNT_W-1:0] r_entry_total, n_entry_total;

    logic [REQ_W-1:0]     r_req;
    logic [IDX_W-1:0]     r_ent;
    logic [GEN_WIDTH-1:0] r_gen_in;
    logic [DATA_W-1:0]    r_px, r_py, r_ps;

    logic [IDX_W-1:0] r_slot, r_moved, r_pop_id;

    logic [GEN_WIDTH-1:0] r_gen_q;
    logic [IDX_W-1:0]     r_fs_q, r_s2e_q, r_e2s_q;
    logic [DATA_W-1:0]    r_x_q, r_y_q, r_sz_q;

    logic [IDX_W-1:0] last_idx;
    logic [IDX_W-1:0] fs_raddr, s2e_raddr, gen_raddr, word_raddr;
    logic [CNT_W-1:0] lim;
    logic             present, ent_out, ent_unissued;
    logic [GEN_WIDTH-1:0] gen_eff;

    logic                 gen_we;
    logic [IDX_W-1:0]     gen_waddr;
    logic [GEN_WIDTH-1:0] gen_wdata;
    logic                 fs_we;
    logic                 s2e_we;
    logic [IDX_W-1:0]     s2e_waddr, s2e_wdata;
    logic                 e2s_we;
    logic [IDX_W-1:0]     e2s_waddr, e2s_wdata;
    logic                 word_we;
    logic [IDX_W-1:0]     word_waddr;
    logic [DATA_W-1:0]    wx, wy, wsz;

    logic [STAT_W-1:0]    n_status;
    logic [IDX_W-1:0]     n_nidx, n_slot_out;
    logic [GEN_WIDTH-1:0] n_ngen;
    logic [DATA_W-1:0]    n_rx, n_ry, n_rs;

    logic                 r_valid;
    logic [STAT_W-1:0]    r_status;
    logic [IDX_W-1:0]     r_nidx, r_slot_out;
    logic [GEN_WIDTH-1:0] r_ngen;
    logic [DATA_W-1:0]    r_rx, r_ry, r_rs;
    logic [CNT_W-1:0]     r_live;

    assign lim          = (r_slot_limit > SLOT_TOTAL) ? SLOT_TOTAL : r_slot_limit;
    assign last_idx     = IDX_W'(r_entry_total - CNT_W'(1));
    assign fs_raddr     = IDX_W'(r_free_depth - CNT_W'(1));
    assign s2e_raddr    = i_cmd.link ? r_e2s_q : last_idx;
    assign gen_raddr    = (r_req == REQ_CREATE) ? r_fs_q : r_ent;
    assign word_raddr   = (r_req == REQ_REMOVE) ? last_idx : r_e2s_q;
    assign present      = (CNT_W'(r_slot) < r_entry_total) && (r_s2e_q == r_ent);
    assign ent_out      = (CNT_W'(r_ent) >= lim);
    assign ent_unissued = (CNT_W'(r_ent) >= r_fresh_next);
    assign gen_eff      = ent_unissued ? '0 : r_gen_q;

    always_comb begin
        gen_we        = 1'b0;
        gen_waddr     = r_pop_id;
        gen_wdata     = GEN_WIDTH'(r_gen_q + GEN_WIDTH'(1));
        fs_we         = 1'b0;
        s2e_we        = 1'b0;
        s2e_waddr     = r_slot;
        s2e_wdata     = r_moved;
        e2s_we        = 1'b0;
        e2s_waddr     = r_moved;
        e2s_wdata     = r_slot;
        word_we       = 1'b0;
        word_waddr    = r_slot;
        wx            = r_px;
        wy            = r_py;
        wsz           = r_ps;
        n_free_depth  = r_free_depth;
        n_fresh_next  = r_fresh_next;
        n_entry_total = r_entry_total;
        n_status      = ST_OK;
        n_nidx        = '0;
        n_ngen        = '0;
        n_slot_out    = '0;
        n_rx          = '0;
        n_ry          = '0;
        n_rs          = '0;
        if (i_cmd.exec) begin
            case (r_req)
                REQ_CREATE: begin
                    if (r_free_depth != '0) begin
                        gen_we       = 1'b1;
                        n_free_depth = r_free_depth - CNT_W'(1);
                        n_nidx       = r_pop_id;
                        n_ngen       = gen_wdata;
                    end else if (r_fresh_next < lim) begin
                        gen_we       = 1'b1;
                        gen_waddr    = IDX_W'(r_fresh_next);
                        gen_wdata    = '0;
                        n_fresh_next = r_fresh_next + CNT_W'(1);
                        n_nidx       = IDX_W'(r_fresh_next);
                    end else begin
                        n_status = ST_FULL;
                    end
                end
                REQ_ADD: begin
                    if (ent_out || ent_unissued) begin
                        n_status = ST_ABSENT;
                    end else if (r_gen_q != r_gen_in) begin
                        n_status = ST_STALE;
                    end else if (present) begin
                        word_we = 1'b1;
                    end else if (r_entry_total >= lim) begin
                        n_status = ST_FULL;
                    end else begin
                        word_we       = 1'b1;
                        word_waddr    = IDX_W'(r_entry_total);
                        s2e_we        = 1'b1;
                        s2e_waddr     = IDX_W'(r_entry_total);
                        s2e_wdata     = r_ent;
                        e2s_we        = 1'b1;
                        e2s_waddr     = r_ent;
                        e2s_wdata     = IDX_W'(r_entry_total);
                        n_entry_total = r_entry_total + CNT_W'(1);
                    end
                end
                REQ_REMOVE: begin
                    if (ent_out) begin
                        n_status = ST_ABSENT;
                    end else if (gen_eff != r_gen_in) begin
                        n_status = ST_STALE;
                    end else if (present) begin
                        word_we       = 1'b1;
                        wx            = r_x_q;
                        wy            = r_y_q;
                        wsz           = r_sz_q;
                        s2e_we        = 1'b1;
                        e2s_we        = 1'b1;
                        n_entry_total = r_entry_total - CNT_W'(1);
                        if (r_free_depth < SLOT_TOTAL) begin
                            fs_we        = 1'b1;
                            n_free_depth = r_free_depth + CNT_W'(1);
                        end
                    end else begin
                        n_status = ST_ABSENT;
                    end
                end
                REQ_LOOKUP: begin
                    if (ent_out) begin
                        n_status = ST_ABSENT;
                    end else if (present) begin
                        n_slot_out = r_slot;
                        n_rx       = r_x_q;
                        n_ry       = r_y_q;
                        n_rs       = r_sz_q;
                    end else begin
                        n_status = ST_ABSENT;
                    end
                end
                REQ_CLEAR: begin
                    n_entry_total = '0;
                end
                default: begin
                    n_status = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_limit  <= LIMIT_RESET;
            r_free_depth  <= '0;
            r_fresh_next  <= '0;
            r_entry_total <= '0;
            r_valid       <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_slot_limit <= i_cfg_wr_data;
            end
            r_free_depth  <= n_free_depth;
            r_fresh_next  <= n_fresh_next;
            r_entry_total <= n_entry_total;
            r_valid       <= i_cmd.exec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req    <= i_req_type;
            r_ent    <= i_entity_index;
            r_gen_in <= i_generation;
            r_px     <= i_payload_x;
            r_py     <= i_payload_y;
            r_ps     <= i_payload_size;
        end
        if (i_cmd.link) begin
            r_slot   <= r_e2s_q;
            r_moved  <= r_s2e_q;
            r_pop_id <= r_fs_q;
        end
        if (i_cmd.exec) begin
            r_status   <= n_status;
            r_nidx     <= n_nidx;
            r_ngen     <= n_ngen;
            r_slot_out <= n_slot_out;
            r_rx       <= n_rx;
            r_ry       <= n_ry;
            r_rs       <= n_rs;
            r_live     <= n_entry_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (gen_we) begin
            mem_gen[gen_waddr] <= gen_wdata;
        end
        r_gen_q <= mem_gen[gen_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (fs_we) begin
            mem_fs[IDX_W'(r_free_depth)] <= r_ent;
        end
        r_fs_q <= mem_fs[fs_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (s2e_we) begin
            mem_s2e[s2e_waddr] <= s2e_wdata;
        end
        r_s2e_q <= mem_s2e[s2e_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (e2s_we) begin
            mem_e2s[e2s_waddr] <= e2s_wdata;
        end
        r_e2s_q <= mem_e2s[i_entity_index];
    end

    always_ff @(posedge i_clk) begin
        if (word_we) begin
            mem_x[word_waddr]  <= wx;
            mem_y[word_waddr]  <= wy;
            mem_sz[word_waddr] <= wsz;
        end
        r_x_q  <= mem_x[word_raddr];
        r_y_q  <= mem_y[word_raddr];
        r_sz_q <= mem_sz[word_raddr];
    end

    assign o_result_valid   = r_valid;
    assign o_out_status     = r_status;
    assign o_new_index      = r_nidx;
    assign o_new_generation = r_ngen;
    assign o_slot_index     = r_slot_out;
    assign o_read_x         = r_rx;
    assign o_read_y         = r_ry;
    assign o_read_size      = r_rs;
    assign o_live_count     = r_live;

endmodule

`default_nettype wire

[rtl/generational_sparse_set.sv]
// Top level of the generational sparse set: entity-ID allocator and packed store.
// Depends on gss_pkg, gss_ctrl and gss_dp.
//
// Usage:
//   Request channel: drive i_req_type, i_entity_index, i_generation and the three
//   payload words with start high; the transfer happens at the edge where busy is
//   low. busy stays high while the request passes the link and execute states.
//   Result channel: o_result_valid is high for exactly one cycle, with all result
//   fields, registered at the end of the execute state. There is no back-pressure: the
//   receiver must take the result in that cycle.
//   Requests do not overlap: a new one is taken only after the two dependent memory
//   reads (entity link, then slot link and payload) and the write of the last one.
//   Configuration: i_cfg_wr_en with i_cfg_wr_data writes slot_limit at the edge;
//   write it only while no request is in flight.
//   Reset (i_rst_n low, synchronous): counters clear, slot_limit returns to 1024,
//   the strobe drops. No memory sweep is needed; the block takes requests at once.
`default_nettype none

module generational_sparse_set
    import gss_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [CNT_W-1:0]     i_cfg_wr_data,
    input  wire logic [REQ_W-1:0]     i_req_type,
    input  wire logic [IDX_W-1:0]     i_entity_index,
    input  wire logic [GEN_WIDTH-1:0] i_generation,
    input  wire logic [DATA_W-1:0]    i_payload_x,
    input  wire logic [DATA_W-1:0]    i_payload_y,
    input  wire logic [DATA_W-1:0]    i_payload_size,
    output logic                      o_result_valid,
    output logic [STAT_W-1:0]         o_out_status,
    output logic [IDX_W-1:0]          o_new_index,
    output logic [GEN_WIDTH-1:0]      o_new_generation,
    output logic [IDX_W-1:0]          o_slot_index,
    output logic [DATA_W-1:0]         o_read_x,
    output logic [DATA_W-1:0]         o_read_y,
    output logic [DATA_W-1:0]         o_read_size,
    output logic [CNT_W-1:0]          o_live_count
);

    t_cmd cmd;

    gss_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (cmd)
    );

    gss_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_req_type       (i_req_type),
        .i_entity_index   (i_entity_index),
        .i_generation     (i_generation),
        .i_payload_x      (i_payload_x),
        .i_payload_y      (i_payload_y),
        .i_payload_size   (i_payload_size),
        .o_result_valid   (o_result_valid),
        .o_out_status     (o_out_status),
        .o_new_index      (o_new_index),
        .o_new_generation (o_new_generation),
        .o_slot_index     (o_slot_index),
        .o_read_x         (o_read_x),
        .o_read_y         (o_read_y),
        .o_read_size      (o_read_size),
        .o_live_count     (o_live_count)
    );

endmodule

`default_nettype wire

[rtl/gss_checker.sv]
// Port-level checker for generational_sparse_set, attached by bind.
// Depends on gss_pkg for widths.
`default_nettype none

module gss_checker
    import gss_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             start,
    input wire logic             busy,
    input wire logic             o_result_valid,
    input wire logic [CNT_W-1:0] o_live_count
);

    a_result_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##3 o_result_valid)
        else $error("result strobe missing three cycles after transfer");

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy low right after transfer");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe held longer than one cycle");

    a_strobe_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (!busy && (o_live_count <= SLOT_TOTAL)))
        else $error("result while busy or live count beyond capacity");

endmodule

bind generational_sparse_set gss_checker u_gss_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_result_valid (o_result_valid),
    .o_live_count   (o_live_count)
);

`default_nettype wire

[dv/tb_top.sv]
`timescale 1ns / 1ps
// Testbench for generational_sparse_set: queued requests go through the start/busy handshake
// and each result is checked against an in-bench model of the ID allocator and packed store.
// Depends on gss_pkg and the generational_sparse_set RTL.

module tb_top;
    import gss_pkg::*;

    typedef struct packed {
        logic [REQ_W-1:0]     kind;
        logic [IDX_W-1:0]     ent;
        logic [GEN_WIDTH-1:0] gen;
        logic [DATA_W-1:0]    px;
        logic [DATA_W-1:0]    py;
        logic [DATA_W-1:0]    psz;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0]    status;
        logic [IDX_W-1:0]     new_idx;
        logic [GEN_WIDTH-1:0] new_gen;
        logic [IDX_W-1:0]     slot;
        logic [DATA_W-1:0]    rx;
        logic [DATA_W-1:0]    ry;
        logic [DATA_W-1:0]    rsz;
        logic [CNT_W-1:0]     live;
    } resp_t;

    typedef struct packed {
        req_t  rq;
        resp_t rs;
    } job_t;

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 start          = 1'b0;
    logic                 busy;
    logic                 i_cfg_wr_en    = 1'b0;
    logic [CNT_W-1:0]     i_cfg_wr_data  = '0;
    logic [REQ_W-1:0]     i_req_type     = '0;
    logic [IDX_W-1:0]     i_entity_index = '0;
    logic [GEN_WIDTH-1:0] i_generation   = '0;
    logic [DATA_W-1:0]    i_payload_x    = '0;
    logic [DATA_W-1:0]    i_payload_y    = '0;
    logic [DATA_W-1:0]    i_payload_size = '0;
    logic                 o_result_valid;
    logic [STAT_W-1:0]    o_out_status;
    logic [IDX_W-1:0]     o_new_index;
    logic [GEN_WIDTH-1:0] o_new_generation;
    logic [IDX_W-1:0]     o_slot_index;
    logic [DATA_W-1:0]    o_read_x;
    logic [DATA_W-1:0]    o_read_y;
    logic [DATA_W-1:0]    o_read_size;
    logic [CNT_W-1:0]     o_live_count;

    generational_sparse_set dut (.*);

    always #2 i_clk = ~i_clk;

    logic [GEN_WIDTH-1:0] gen_mem    [SLOT_COUNT];
    logic [IDX_W-1:0]     free_ids   [SLOT_COUNT];
    logic [IDX_W-1:0]     slot_owner [SLOT_COUNT];
    logic [IDX_W-1:0]     owner_slot [SLOT_COUNT];
    logic [DATA_W-1:0]    x_mem      [SLOT_COUNT];
    logic [DATA_W-1:0]    y_mem      [SLOT_COUNT];
    logic [DATA_W-1:0]    sz_mem     [SLOT_COUNT];
    logic [CNT_W-1:0]     free_top;
    logic [CNT_W-1:0]     next_fresh;
    logic [CNT_W-1:0]     live_n;
    logic [CNT_W-1:0]     limit_q;

    job_t  req_backlog [$];
    resp_t resp_due [$];
    resp_t drv_resp;
    int    idle_left = 0;
    int    acc_cnt   = 0;
    int    err_cnt   = 0;

    function automatic logic [CNT_W-1:0] active_limit();
        return (limit_q > SLOT_TOTAL) ? SLOT_TOTAL : limit_q;
    endfunction

    function automatic logic entity_live(logic [IDX_W-1:0] e);
        logic [IDX_W-1:0] s;
        s = owner_slot[e];
        return ({1'b0, s} < live_n) && (slot_owner[s] == e);
    endfunction

    function automatic void store_words(logic [IDX_W-1:0] s, req_t r);
        x_mem[s]  = r.px;
        y_mem[s]  = r.py;
        sz_mem[s] = r.psz;
    endfunction

    function automatic resp_t apply_request(req_t r);
        resp_t            o;
        logic [CNT_W-1:0] lim;
        logic [IDX_W-1:0] id;
        logic [IDX_W-1:0] s;
        logic [IDX_W-1:0] last;
        logic [IDX_W-1:0] moved;
        o   = '0;
        lim = active_limit();
        case (r.kind)
            REQ_CREATE: begin
                if (free_top != 0) begin
                    free_top = free_top - 1'b1;
                    id = free_ids[free_top[IDX_W-1:0]];
                    gen_mem[id] = gen_mem[id] + 1'b1;
                    o.new_idx = id;
                    o.new_gen = gen_mem[id];
                end else if (next_fresh < lim) begin
                    id = next_fresh[IDX_W-1:0];
                    next_fresh = next_fresh + 1'b1;
                    gen_mem[id] = '0;
                    o.new_idx = id;
                end else begin
                    o.status = ST_FULL;
                end
            end
            REQ_ADD: begin
                if ({1'b0, r.ent} >= lim || {1'b0, r.ent} >= next_fresh) begin
                    o.status = ST_ABSENT;
                end else if (gen_mem[r.ent] != r.gen) begin
                    o.status = ST_STALE;
                end else if (entity_live(r.ent)) begin
                    store_words(owner_slot[r.ent], r);
                end else if (live_n >= lim) begin
                    o.status = ST_FULL;
                end else begin
                    s = live_n[IDX_W-1:0];
                    slot_owner[s] = r.ent;
                    owner_slot[r.ent] = s;
                    store_words(s, r);
                    live_n = live_n + 1'b1;
                end
            end
            REQ_REMOVE: begin
                if ({1'b0, r.ent} >= lim) begin
                    o.status = ST_ABSENT;
                end else if (gen_mem[r.ent] != r.gen) begin
                    o.status = ST_STALE;
                end else if (!entity_live(r.ent)) begin
                    o.status = ST_ABSENT;
                end else begin
                    s = owner_slot[r.ent];
                    last = IDX_W'(live_n - 1'b1);
                    moved = slot_owner[last];
                    slot_owner[s] = moved;
                    x_mem[s] = x_mem[last];
                    y_mem[s] = y_mem[last];
                    sz_mem[s] = sz_mem[last];
                    owner_slot[moved] = s;
                    live_n = live_n - 1'b1;
                    if (free_top < SLOT_TOTAL) begin
                        free_ids[free_top[IDX_W-1:0]] = r.ent;
                        free_top = free_top + 1'b1;
                    end
                end
            end
            REQ_LOOKUP: begin
                if ({1'b0, r.ent} >= lim || !entity_live(r.ent)) begin
                    o.status = ST_ABSENT;
                end else begin
                    o.slot = owner_slot[r.ent];
                    o.rx   = x_mem[o.slot];
                    o.ry   = y_mem[o.slot];
                    o.rsz  = sz_mem[o.slot];
                end
            end
            REQ_CLEAR: begin
                live_n = '0;
            end
            default: ;
        endcase
        o.live = live_n;
        return o;
    endfunction

    // mostly well-formed requests built from the current model state, some raw noise
    function automatic req_t pick_item(int w_create, int w_add, int w_remove, int w_lookup);
        req_t r;
        int   roll;
        int   span;
        r.kind = REQ_W'($urandom);
        r.ent  = IDX_W'($urandom);
        r.gen  = GEN_WIDTH'($urandom);
        r.px   = $urandom;
        r.py   = $urandom;
        r.psz  = $urandom;
        span = (next_fresh < active_limit()) ? int'(next_fresh) : int'(active_limit());
        roll = $urandom_range(99);
        if (roll < 10) return r;
        if (roll < 12) begin
            r.kind = REQ_CLEAR;
            return r;
        end
        roll = $urandom_range(w_create + w_add + w_remove + w_lookup - 1);
        if (roll < w_create) begin
            r.kind = REQ_CREATE;
        end else if (roll < w_create + w_add) begin
            r.kind = REQ_ADD;
            if (span > 0) r.ent = IDX_W'($urandom_range(span - 1));
        end else if (roll < w_create + w_add + w_remove) begin
            r.kind = REQ_REMOVE;
            if (live_n != 0) r.ent = slot_owner[$urandom_range(int'(live_n) - 1)];
        end else begin
            r.kind = REQ_LOOKUP;
            if (live_n != 0 && $urandom_range(9) < 7)
                r.ent = slot_owner[$urandom_range(int'(live_n) - 1)];
        end
        if (r.kind != REQ_CREATE && $urandom_range(9) != 0) r.gen = gen_mem[r.ent];
        return r;
    endfunction

    task automatic queue_item(req_t r);
        job_t j;
        j.rq = r;
        j.rs = apply_request(r);
        req_backlog.push_back(j);
    endtask

    task automatic wait_idle();
        while (req_backlog.size() != 0 || resp_due.size() != 0 || start) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic write_limit(logic [CNT_W-1:0] v);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        limit_q = v;
    endtask

    task automatic run_phase(logic [CNT_W-1:0] lim, int n, int wc, int wa, int wr, int wl);
        write_limit(lim);
        repeat (n) queue_item(pick_item(wc, wa, wr, wl));
        wait_idle();
    endtask

    function automatic void check_field(string name, logic [DATA_W-1:0] want,
                                        logic [DATA_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            err_cnt++;
        end
    endfunction

    // request driver
    always @(posedge i_clk) begin
        job_t j;
        logic quiet;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            quiet = (acc_cnt >= 300 && acc_cnt < 800);
            if (start && !busy) begin
                resp_due.push_back(drv_resp);
                acc_cnt++;
            end
            if (!start || !busy) begin
                if (idle_left > 0) begin
                    idle_left--;
                    start <= 1'b0;
                end else if (req_backlog.size() == 0) begin
                    start <= 1'b0;
                end else if (!quiet && $urandom_range(99) < 17) begin
                    idle_left = $urandom_range(4);
                    start <= 1'b0;
                end else begin
                    j = req_backlog.pop_front();
                    i_req_type     <= j.rq.kind;
                    i_entity_index <= j.rq.ent;
                    i_generation   <= j.rq.gen;
                    i_payload_x    <= j.rq.px;
                    i_payload_y    <= j.rq.py;
                    i_payload_size <= j.rq.psz;
                    drv_resp = j.rs;
                    start <= 1'b1;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        resp_t e;
        if (i_rst_n && o_result_valid) begin
            if (resp_due.size() == 0) begin
                $display("%0t: result with none pending: expected nothing, actual status %0d",
                         $time, o_out_status);
                err_cnt++;
            end else begin
                e = resp_due.pop_front();
                check_field("status",         e.status,  o_out_status);
                check_field("new_index",      e.new_idx, o_new_index);
                check_field("new_generation", e.new_gen, o_new_generation);
                check_field("slot_index",     e.slot,    o_slot_index);
                check_field("read_x",         e.rx,      o_read_x);
                check_field("read_y",         e.ry,      o_read_y);
                check_field("read_size",      e.rsz,     o_read_size);
                check_field("live_count",     e.live,    o_live_count);
            end
        end
    end

    initial begin
        int guard;
        for (int k = 0; k < SLOT_COUNT; k++) begin
            gen_mem[k]    = '0;
            free_ids[k]   = '0;
            slot_owner[k] = '0;
            owner_slot[k] = '0;
            x_mem[k]      = '0;
            y_mem[k]      = '0;
            sz_mem[k]     = '0;
        end
        free_top   = '0;
        next_fresh = '0;
        live_n     = '0;
        limit_q    = LIMIT_RESET;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        queue_item('{REQ_LOOKUP, 10'd0,    16'd0,      32'd0, 32'd0, 32'd0});
        queue_item('{REQ_ADD,    10'd0,    16'd0,      32'd1, 32'd2, 32'd3});
        queue_item('{REQ_REMOVE, 10'd1023, 16'hFFFF,   32'd0, 32'd0, 32'd0});
        queue_item('{REQ_REMOVE, 10'd5,    16'd0,      32'd0, 32'd0, 32'd0});
        repeat (3) queue_item('{REQ_CREATE, 10'd0, 16'd0, 32'd0, 32'd0, 32'd0});
        queue_item('{REQ_ADD,    10'd0,    16'd0,
                     32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
        queue_item('{REQ_ADD,    10'd1,    16'd0,      32'd0, 32'd0, 32'd0});
        queue_item('{REQ_ADD,    10'd2,    16'hFFFF,   32'd7, 32'd8, 32'd9});
        queue_item('{REQ_ADD,    10'd0,    16'd0,
                     32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'h8000_0001});
        queue_item('{REQ_LOOKUP, 10'd0,    16'd0,      32'd0, 32'd0, 32'd0});
        queue_item('{REQ_LOOKUP, 10'd1,    16'd0,      32'd0, 32'd0, 32'd0});
        queue_item('{REQ_REMOVE, 10'd0,    16'd0,      32'd0, 32'd0, 32'd0});
        queue_item('{REQ_LOOKUP, 10'd1,    16'hFFFF,   32'd0, 32'd0, 32'd0});
        queue_item('{REQ_REMOVE, 10'd0,    16'd0,      32'd0, 32'd0, 32'd0});
        queue_item('{REQ_CREATE, 10'd1023, 16'hFFFF,   32'd0, 32'd0, 32'd0});
        queue_item('{REQ_ADD,    10'd0,    16'd0,      32'd4, 32'd5, 32'd6});
        queue_item('{REQ_LOOKUP, 10'd1023, 16'd0,      32'd0, 32'd0, 32'd0});
        queue_item('{REQ_CLEAR,  10'd0,    16'd0,      32'd0, 32'd0, 32'd0});
        queue_item('{REQ_LOOKUP, 10'd1,    16'd0,      32'd0, 32'd0, 32'd0});
        for (int k = REQ_CLEAR + 1; k < 2 ** REQ_W; k++)
            queue_item('{REQ_W'(k), IDX_W'($urandom), GEN_WIDTH'($urandom),
                         $urandom, $urandom, $urandom});
        wait_idle();

        run_phase(SLOT_TOTAL,   300, 30, 35, 15, 18);
        run_phase(CNT_W'(1),    120, 30, 40, 15, 13);
        run_phase('0,            40, 30, 30, 20, 18);
        run_phase('1,           150, 25, 35, 20, 18);

        // churn add/remove to pile up freed indices
        write_limit(SLOT_TOTAL);
        guard = 0;
        while (free_top < SLOT_TOTAL && guard < 850) begin
            queue_item(pick_item(0, 45, 50, 5));
            guard++;
        end
        repeat (60) queue_item(pick_item(0, 45, 50, 5));
        wait_idle();

        run_phase(CNT_W'(5),    150, 40, 30, 15, 13);
        run_phase(CNT_W'(64),   200, 35, 35, 15, 13);

        if (err_cnt == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

[filelist.f]
rtl/gss_pkg.sv
rtl/gss_ctrl.sv
rtl/gss_dp.sv
rtl/generational_sparse_set.sv
rtl/gss_checker.sv
dv/tb_top.sv
